// ===== src/calendar_days_between_core_assert.svh =====
`ifndef CALENDAR_DAYS_BETWEEN_CORE_ASSERT_SVH
`define CALENDAR_DAYS_BETWEEN_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CDB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CDB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/cdb_pkg.sv =====
package cdb_pkg;

  // Field widths.
  localparam int DAY_W   = 7;
  localparam int MONTH_W = 7;
  localparam int YEAR_W  = 14;
  localparam int ORD_W   = 23;
  localparam int PC_W    = 3;

  // Calendar constants.
  localparam logic [3:0]   MONTHS_PER_YEAR = 4'd12;
  localparam logic [8:0]   DAYS_PER_YEAR   = 9'd365;
  localparam logic [6:0]   CENTURY         = 7'd100;
  localparam logic [6:0]   CEIL_BIAS       = 7'd99;

  // Division by 100 as a multiply by 2^19/100, exact for operands below 2^15.
  localparam logic [12:0]  RECIP100    = 13'd5243;
  localparam int           RECIP_SHIFT = 19;
  localparam int           PROD_W      = 28;
  localparam int           QUOT_W      = 8;

  // Datapath operations of one microcode step.
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MUL_CEIL,
    OP_MUL_FLOOR,
    OP_YEARS,
    OP_LEAPS,
    OP_MONTHS,
    OP_STORE,
    OP_FINISH
  } op_t;

  // Jump conditions.
  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ABSENT,
    JMP_FIRST
  } jmp_t;

  typedef struct packed {
    op_t             op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_START  = 3'd0;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd7;

  // Microprogram: one date is reduced to its day ordinal in steps zero to six,
  // the store step loops back once for the second date.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      3'd0:    w = '{OP_LOAD,      JMP_ABSENT, PC_FINISH};
      3'd1:    w = '{OP_MUL_CEIL,  JMP_NONE,   PC_START};
      3'd2:    w = '{OP_MUL_FLOOR, JMP_NONE,   PC_START};
      3'd3:    w = '{OP_YEARS,     JMP_NONE,   PC_START};
      3'd4:    w = '{OP_LEAPS,     JMP_NONE,   PC_START};
      3'd5:    w = '{OP_MONTHS,    JMP_NONE,   PC_START};
      3'd6:    w = '{OP_STORE,     JMP_FIRST,  PC_START};
      default: w = '{OP_FINISH,    JMP_NONE,   PC_START};
    endcase
    return w;
  endfunction

  // Days in the months before the given month of a common year.
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/calendar_days_between_core.sv =====
// Days strictly between two Gregorian dates. After a transfer on the input
// channel the core stalls its input and runs a short microprogram on one
// shared 15x13 multiplier: seven steps per date and one finishing step; with
// a date absent it goes from the load step straight to the finishing step and
// the result is -1. A new item is taken only once the finishing step is done.
// The result sits in an output register, and the next item is accepted while
// it waits to be taken.
module calendar_days_between_core
  import cdb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      first_present,
  input  logic                      second_present,
  input  logic [DAY_W-1:0]          day1,
  input  logic [MONTH_W-1:0]        month1,
  input  logic [YEAR_W-1:0]         year1,
  input  logic [DAY_W-1:0]          day2,
  input  logic [MONTH_W-1:0]        month2,
  input  logic [YEAR_W-1:0]         year2,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ORD_W-1:0]   days_between
);

  // Control state.
  logic            busy;
  logic [PC_W-1:0] pc;
  logic            sel;

  // Latched input item.
  logic               present;
  logic [DAY_W-1:0]   d1_r, d2_r;
  logic [MONTH_W-1:0] m1_r, m2_r;
  logic [YEAR_W-1:0]  y1_r, y2_r;

  // Datapath registers.
  logic [YEAR_W-1:0] yr;
  logic [3:0]        mo;
  logic [DAY_W-1:0]  dy;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] cq;
  logic [QUOT_W-1:0] qf;
  logic              leap;
  logic [ORD_W-1:0]  acc;
  logic [ORD_W-1:0]  ord_a;

  ctrl_t ctrl;
  logic  in_xfer;
  logic  step_go;
  logic  jump;

  // Selected date for the current pass.
  logic [DAY_W-1:0]   d_sel;
  logic [MONTH_W-1:0] m_sel;
  logic [YEAR_W-1:0]  y_sel;

  // Shared multiplier operand.
  logic [YEAR_W:0] mul_a;

  // Leap-year and leap-count terms.
  logic             y_div100;
  logic             leap_now;
  logic [12:0]      ceil4;
  logic [QUOT_W:0]  ceil400;
  logic [ORD_W-1:0] leap_count;
  logic [ORD_W-1:0] month_days;
  logic [ORD_W-1:0] diff;

  assign ctrl     = ucode(pc);
  assign in_stall = busy;
  assign in_xfer  = in_valid && !busy;
  assign step_go  = busy && !(ctrl.op == OP_FINISH && out_valid && out_stall);

  assign d_sel = sel ? d2_r : d1_r;
  assign m_sel = sel ? m2_r : m1_r;
  assign y_sel = sel ? y2_r : y1_r;

  assign mul_a = (ctrl.op == OP_MUL_CEIL) ? ({1'b0, yr} + (YEAR_W + 1)'(CEIL_BIAS))
                                          : {1'b0, yr};

  // A year divisible by 100 equals 100 times its floor quotient.
  assign y_div100 = ((YEAR_W + 1)'(qf) * (YEAR_W + 1)'(CENTURY)) == {1'b0, yr};
  assign leap_now = (yr[1:0] == 2'b00) && (!y_div100 || (qf[1:0] == 2'b00));

  // Leap years in 0..y-1 as ceil(y/4) - ceil(y/100) + ceil(y/400).
  always_comb begin
    logic [YEAR_W:0] y_plus3;
    y_plus3    = {1'b0, yr} + (YEAR_W + 1)'(3);
    ceil4      = y_plus3[YEAR_W:2];
    ceil400    = ({1'b0, cq} + (QUOT_W + 1)'(3)) >> 2;
    leap_count = ORD_W'(ceil4) - ORD_W'(cq) + ORD_W'(ceil400);
  end

  // Months before the given one plus the day, with February 29 in leap years.
  assign month_days = ORD_W'(days_before_month(mo))
                    + ORD_W'(leap && (mo >= 4'd3))
                    + ORD_W'(dy);

  assign diff = (ord_a > acc) ? (ord_a - acc) : (acc - ord_a);

  always_comb begin
    jump = 1'b0;
    case (ctrl.jmp)
      JMP_ABSENT: jump = !present;
      JMP_FIRST:  jump = !sel;
      default:    jump = 1'b0;
    endcase
  end

  // Sequencer and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= PC_START;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
        pc   <= PC_START;
        sel  <= 1'b0;
      end else if (step_go) begin
        if (ctrl.op == OP_FINISH) begin
          busy <= 1'b0;
          pc   <= PC_START;
        end else begin
          pc <= jump ? ctrl.target : pc + PC_W'(1);
          if (ctrl.op == OP_STORE) begin
            sel <= 1'b1;
          end
        end
      end
      // A finished item fills the output register; a taken result empties it.
      if (step_go && ctrl.op == OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input latch and datapath.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      present <= first_present && second_present;
      d1_r    <= day1;
      m1_r    <= month1;
      y1_r    <= year1;
      d2_r    <= day2;
      m2_r    <= month2;
      y2_r    <= year2;
    end
    if (step_go) begin
      case (ctrl.op)
        OP_LOAD: begin
          yr <= y_sel;
          dy <= d_sel;
          mo <= (m_sel > MONTH_W'(MONTHS_PER_YEAR)) ? MONTHS_PER_YEAR : m_sel[3:0];
        end
        OP_MUL_CEIL: begin
          prod <= PROD_W'(mul_a) * PROD_W'(RECIP100);
        end
        OP_MUL_FLOOR: begin
          cq   <= prod[RECIP_SHIFT +: QUOT_W];
          prod <= PROD_W'(mul_a) * PROD_W'(RECIP100);
        end
        OP_YEARS: begin
          qf  <= prod[RECIP_SHIFT +: QUOT_W];
          acc <= ORD_W'(yr) * ORD_W'(DAYS_PER_YEAR);
        end
        OP_LEAPS: begin
          leap <= leap_now;
          acc  <= acc + leap_count;
        end
        OP_MONTHS: begin
          acc <= acc + month_days;
        end
        OP_STORE: begin
          if (!sel) begin
            ord_a <= acc;
          end
        end
        OP_FINISH: begin
          if (!present) begin
            days_between <= '1;
          end else if (diff <= ORD_W'(1)) begin
            days_between <= '0;
          end else begin
            days_between <= diff - ORD_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/cdb_checker.sv =====
`include "calendar_days_between_core_assert.svh"

module cdb_checker
  import cdb_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [ORD_W-1:0] days_between
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // An accepted item keeps the input stalled while it is worked on.
  `CDB_ASSERT_NXT(a_busy_after_xfer, clk, rst, in_xfer, in_stall)

  // No result appears sooner than the shortest microprogram path.
  `CDB_ASSERT_IMP(a_min_latency, clk, rst, in_xfer, ##2 !$rose(out_valid))

  // The input is free whenever a new result appears.
  `CDB_ASSERT_IMP(a_result_frees_input, clk, rst, $rose(out_valid), !in_stall)

  // A stalled result holds.
  `CDB_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall,
                  out_valid && $stable(days_between))

endmodule

bind calendar_days_between_core cdb_checker u_cdb_checker (.*);
